[rtl/i2cbr_pkg.sv]
// ----------------------------------------------------------------------------
// i2cbr_pkg
// Types and constants shared by the I2C bus clear recovery sequencer.
// ----------------------------------------------------------------------------
package i2cbr_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 24;
  localparam int unsigned TickWidth     = 24;
  localparam int unsigned HalfWidth     = 16;
  localparam int unsigned CountWidth    = 8;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CfgSettleTicks     = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CfgHalfPeriodTicks = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CfgPollTicks       = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CfgStretchPolls    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CfgMaxPulses       = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [TickWidth-1:0]  SettleTicksReset     = 24'd500000;
  localparam logic [HalfWidth-1:0]  HalfPeriodTicksReset = 16'd10;
  localparam logic [TickWidth-1:0]  PollTicksReset       = 24'd100000;
  localparam logic [CountWidth-1:0] StretchPollsReset    = 8'd20;
  localparam logic [CountWidth-1:0] MaxPulsesReset       = 8'd20;

  // Completion status codes.
  localparam logic [1:0] StatusCleared        = 2'd0;
  localparam logic [1:0] StatusSclLow         = 2'd1;
  localparam logic [1:0] StatusStretchTimeout = 2'd2;
  localparam logic [1:0] StatusSdaStuck       = 2'd3;

  typedef struct packed {
    logic start_req;
    logic scl_level;
    logic sda_level;
  } in_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_t;

endpackage

[rtl/i2c_bus_recovery_core.sv]
// ----------------------------------------------------------------------------
// i2c_bus_recovery_core
// I2C bus clear sequencer: settle, SCL pulses while SDA is low with clock
// stretch polling, then a start and stop, reporting a status code.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                           | Payload
//  --------+-----------------------------------+---------------------------
//  in      | in_valid, in_ready, in_data       | i2cbr_pkg::in_t (one tick)
//  out     | out_valid, out_ready, out_data    | i2cbr_pkg::out_t
//  cfg     | cfg_valid, cfg_ready, cfg_index,  | register index, write data
//          | cfg_data                          |
//
// Every tick request is handled at the edge that accepts it; the sequencer
// state and the result register update at that edge, so one request per
// clock is taken while the result register is empty or being drained.
// Reset returns the sequencer to idle, empties the result register and
// loads the register defaults. A stall on the output holds in_ready low.
// Configuration writes are always accepted.
module i2c_bus_recovery_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  i2cbr_pkg::in_t                        in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output i2cbr_pkg::out_t                       out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [i2cbr_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [i2cbr_pkg::CfgDataWidth-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETTLE,
    PH_PULSE_LOW,
    PH_PULSE_HIGH,
    PH_STRETCH,
    PH_SDA_LOW,
    PH_SDA_HIGH
  } phase_t;

  logic [i2cbr_pkg::TickWidth-1:0]  settle_ticks;
  logic [i2cbr_pkg::HalfWidth-1:0]  half_period_ticks;
  logic [i2cbr_pkg::TickWidth-1:0]  poll_ticks;
  logic [i2cbr_pkg::CountWidth-1:0] stretch_polls;
  logic [i2cbr_pkg::CountWidth-1:0] max_pulses;

  phase_t                           phase, phase_next;
  logic [i2cbr_pkg::TickWidth-1:0]  tick_count, tick_count_next;
  logic [i2cbr_pkg::CountWidth-1:0] pulses_left, pulses_left_next;
  logic [i2cbr_pkg::CountWidth-1:0] polls_left, polls_left_next;
  logic [1:0]                       last_status, last_status_next;
  logic                             done_next;

  logic [i2cbr_pkg::TickWidth-1:0]  tick_inc;
  logic                             half_hit;
  logic                             poll_hit;
  logic [i2cbr_pkg::CountWidth-1:0] pulse_src;
  logic [i2cbr_pkg::CountWidth-1:0] polls_dec;
  logic                             accept;
  i2cbr_pkg::out_t                  result;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign tick_inc  = tick_count + 1'b1;
  // A limit of zero behaves like one, which falls out of the >= compare.
  assign half_hit  = tick_inc >= {{(i2cbr_pkg::TickWidth - i2cbr_pkg::HalfWidth){1'b0}},
                                  half_period_ticks};
  assign poll_hit  = tick_inc >= poll_ticks;
  assign polls_dec = polls_left - 1'b1;
  // On leaving settle the pulse budget is reloaded before it is spent.
  assign pulse_src = (phase == PH_SETTLE) ? max_pulses : pulses_left;

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    pulses_left_next = pulses_left;
    polls_left_next  = polls_left;
    last_status_next = last_status;
    done_next        = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (in_data.start_req) begin
          phase_next      = PH_SETTLE;
          tick_count_next = '0;
        end
      end
      PH_SETTLE: begin
        if (tick_count >= settle_ticks) begin
          tick_count_next = '0;
          if (!in_data.scl_level) begin
            phase_next       = PH_IDLE;
            last_status_next = i2cbr_pkg::StatusSclLow;
            done_next        = 1'b1;
          end else begin
            pulses_left_next = max_pulses;
            if (!in_data.sda_level) begin
              if (pulse_src != '0) begin
                pulses_left_next = pulse_src - 1'b1;
                phase_next       = PH_PULSE_LOW;
              end else begin
                phase_next       = PH_IDLE;
                last_status_next = i2cbr_pkg::StatusSdaStuck;
                done_next        = 1'b1;
              end
            end else begin
              phase_next = PH_SDA_LOW;
            end
          end
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_PULSE_LOW: begin
        tick_count_next = tick_inc;
        if (half_hit) begin
          phase_next      = PH_PULSE_HIGH;
          tick_count_next = '0;
        end
      end
      PH_PULSE_HIGH: begin
        tick_count_next = tick_inc;
        if (half_hit) begin
          tick_count_next = '0;
          if (in_data.scl_level) begin
            if (!in_data.sda_level) begin
              if (pulse_src != '0) begin
                pulses_left_next = pulse_src - 1'b1;
                phase_next       = PH_PULSE_LOW;
              end else begin
                phase_next       = PH_IDLE;
                last_status_next = i2cbr_pkg::StatusSdaStuck;
                done_next        = 1'b1;
              end
            end else begin
              phase_next = PH_SDA_LOW;
            end
          end else begin
            polls_left_next = stretch_polls;
            if (stretch_polls == '0) begin
              phase_next       = PH_IDLE;
              last_status_next = i2cbr_pkg::StatusStretchTimeout;
              done_next        = 1'b1;
            end else begin
              phase_next = PH_STRETCH;
            end
          end
        end
      end
      PH_STRETCH: begin
        tick_count_next = tick_inc;
        if (poll_hit) begin
          polls_left_next = polls_dec;
          tick_count_next = '0;
          if (in_data.scl_level) begin
            if (!in_data.sda_level) begin
              if (pulse_src != '0) begin
                pulses_left_next = pulse_src - 1'b1;
                phase_next       = PH_PULSE_LOW;
              end else begin
                phase_next       = PH_IDLE;
                last_status_next = i2cbr_pkg::StatusSdaStuck;
                done_next        = 1'b1;
              end
            end else begin
              phase_next = PH_SDA_LOW;
            end
          end else if (polls_dec == '0) begin
            phase_next       = PH_IDLE;
            last_status_next = i2cbr_pkg::StatusStretchTimeout;
            done_next        = 1'b1;
          end
        end
      end
      PH_SDA_LOW: begin
        tick_count_next = tick_inc;
        if (half_hit) begin
          phase_next      = PH_SDA_HIGH;
          tick_count_next = '0;
        end
      end
      PH_SDA_HIGH: begin
        tick_count_next = tick_inc;
        if (half_hit) begin
          phase_next       = PH_IDLE;
          tick_count_next  = '0;
          last_status_next = i2cbr_pkg::StatusCleared;
          done_next        = 1'b1;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase
  end

  always_comb begin
    result.scl_drive_low = (phase_next == PH_PULSE_LOW);
    result.sda_drive_low = (phase_next == PH_SDA_LOW);
    result.busy_res      = (phase_next != PH_IDLE);
    result.done_res      = done_next;
    result.status        = last_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      tick_count        <= '0;
      pulses_left       <= '0;
      polls_left        <= '0;
      last_status       <= i2cbr_pkg::StatusCleared;
      out_valid         <= 1'b0;
      settle_ticks      <= i2cbr_pkg::SettleTicksReset;
      half_period_ticks <= i2cbr_pkg::HalfPeriodTicksReset;
      poll_ticks        <= i2cbr_pkg::PollTicksReset;
      stretch_polls     <= i2cbr_pkg::StretchPollsReset;
      max_pulses        <= i2cbr_pkg::MaxPulsesReset;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        tick_count  <= tick_count_next;
        pulses_left <= pulses_left_next;
        polls_left  <= polls_left_next;
        last_status <= last_status_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          i2cbr_pkg::CfgSettleTicks:     settle_ticks      <= cfg_data;
          i2cbr_pkg::CfgHalfPeriodTicks: half_period_ticks <= cfg_data[i2cbr_pkg::HalfWidth-1:0];
          i2cbr_pkg::CfgPollTicks:       poll_ticks        <= cfg_data;
          i2cbr_pkg::CfgStretchPolls:    stretch_polls     <= cfg_data[i2cbr_pkg::CountWidth-1:0];
          i2cbr_pkg::CfgMaxPulses:       max_pulses        <= cfg_data[i2cbr_pkg::CountWidth-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule
